[hw/rtl/eda_pkg.sv]
// Shared types, constants and the exponent table of the ellipsoid activation core.
package eda_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_BITS    = 8;
  localparam int DIV_BITS        = FRAC_BITS + 8;
  localparam int AD_W            = 33;
  localparam int REM_W           = AD_W + FRAC_BITS;
  localparam int DV_W            = 31 + DIV_BITS;
  localparam int X_W             = 23;
  localparam int E_W             = 17;
  localparam int P_W             = 60;
  localparam int DVD_W           = P_W + FRAC_BITS;
  localparam int EXP_SHIFT_BASE  = 30 - FRAC_BITS;

  localparam logic [28:0]   K_Q28     = 29'd500987569;
  localparam logic [63:0]   LOG2E_Q32 = 64'd6196328019;
  localparam logic [16:0]   LOG2E_QF  =
    17'((LOG2E_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic [X_W-1:0] X_MAX    = X_W'(64 << FRAC_BITS);
  localparam logic [30:0]   RADIUS_RESET = 31'(1 << FRAC_BITS);
  localparam logic [31:0]   THRESH_RESET = 32'(1 << (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    REG_RADIUS_X   = 3'd0,
    REG_RADIUS_Y   = 3'd1,
    REG_RADIUS_Z   = 3'd2,
    REG_VELOCITY_X = 3'd3,
    REG_VELOCITY_Y = 3'd4,
    REG_VELOCITY_Z = 3'd5,
    REG_THRESHOLD  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    PF_IDLE,
    PF_CHECK,
    PF_STEP
  } pf_state_t;

  // Flags that travel down the pipeline next to the data.
  typedef struct packed {
    logic valid;
    logic over;
    logic old;
  } side_t;

  // Prefactor unit status toward the top level.
  typedef struct packed {
    logic           busy;
    logic           big;
    logic [P_W-1:0] p;
  } pf_out_t;

  typedef logic [30:0] exp_table_t [EXP_TABLE_DEPTH];

  // A radius of zero behaves as one LSB.
  function automatic logic [30:0] eff_radius(input logic [30:0] r);
    return (r == 31'd0) ? 31'd1 : r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry i is 2^(-i/DEPTH) in Q30, built from the factors 2^(-2^-k).
  function automatic exp_table_t build_exp_table();
    exp_table_t  tab;
    logic [63:0] fac [24];
    logic [63:0] cc;
    logic [63:0] base;
    logic [63:0] g;
    cc = 64'd1 << 29;
    for (int k = 1; k <= 24; k++) begin
      cc = isqrt64(cc << 30);
      fac[k-1] = cc;
    end
    for (int idx = 0; idx < EXP_TABLE_DEPTH; idx++) begin
      g    = 64'(idx) << (24 - EXP_IDX_BITS);
      base = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        if (g[24-k]) base = (base * fac[k-1]) >> 30;
      end
      tab[idx] = base[30:0];
    end
    return tab;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

[hw/rtl/eda_travel.sv]
// Source travel, scan-over test and point-to-centre distance stages.
module eda_travel import eda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  side_t              in_side,
  input  logic signed [31:0] point [3],
  input  logic signed [31:0] start_pos [3],
  input  logic [31:0]        elapsed,
  input  logic [30:0]        len,
  input  logic signed [31:0] vel [3],
  output side_t              out_side,
  output logic [AD_W-1:0]    ad [3]
);

  side_t              side1, side2, side3;
  logic [63:0]        prod1 [3];
  logic               neg1 [3];
  logic signed [32:0] diff1 [3];
  logic [30:0]        len1;
  logic [61:0]        sq2 [3];
  logic [61:0]        len_sq2;
  logic [AD_W-1:0]    ad2 [3];
  logic               ovf2;
  logic [AD_W-1:0]    ad3 [3];

  logic [31:0]        mag [3];
  logic [30:0]        tr [3];
  logic               ovf [3];
  logic signed [33:0] trs [3];
  logic signed [33:0] dd [3];
  logic [33:0]        dabs [3];
  logic [63:0]        dist_sq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = vel[i][31] ? (~vel[i] + 32'd1) : vel[i];
      ovf[i]  = |prod1[i][63:47];
      tr[i]   = prod1[i][46:16];
      trs[i]  = neg1[i] ? -$signed({3'b000, tr[i]}) : $signed({3'b000, tr[i]});
      dd[i]   = $signed({diff1[i][32], diff1[i]}) - trs[i];
      dabs[i] = dd[i][33] ? 34'(-dd[i]) : 34'(dd[i]);
    end
    dist_sq = 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side2 <= '0;
      side3 <= '0;
    end else begin
      side1 <= in_side;
      side2 <= side1;
      side3 <= '{valid: side2.valid,
                 over:  ovf2 | (dist_sq > {2'b00, len_sq2}),
                 old:   side2.old};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod1[i] <= 64'(mag[i]) * 64'(elapsed);
      neg1[i]  <= vel[i][31];
      diff1[i] <= {point[i][31], point[i]} - {start_pos[i][31], start_pos[i]};
      sq2[i]   <= 62'(tr[i]) * 62'(tr[i]);
      ad2[i]   <= dabs[i][AD_W-1:0];
      ad3[i]   <= ad2[i];
    end
    len1    <= len;
    len_sq2 <= 62'(len1) * 62'(len1);
    ovf2    <= ovf[0] | ovf[1] | ovf[2];
  end

  assign out_side = side3;
  assign ad       = ad3;

endmodule

[hw/rtl/eda_ratio_div.sv]
// Pipelined restoring dividers, one quotient bit per stage, for the three axis ratios.
module eda_ratio_div import eda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  side_t               in_side,
  input  logic [AD_W-1:0]     ad [3],
  input  logic [30:0]         radius [3],
  output side_t               out_side,
  output logic [DIV_BITS-1:0] ratio [3]
);

  side_t               side [DIV_BITS+1];
  logic [REM_W-1:0]    rem [3][DIV_BITS+1];
  logic [DIV_BITS-1:0] quo [3][DIV_BITS+1];
  logic                clamp [3][DIV_BITS+1];

  logic [30:0]         r [3];
  logic [DV_W-1:0]     dv [3][DIV_BITS];
  logic                fits [3][DIV_BITS];
  logic [REM_W-1:0]    rem_next [3][DIV_BITS];

  always_comb begin
    for (int ln = 0; ln < 3; ln++) begin
      r[ln] = eff_radius(radius[ln]);
      for (int s = 0; s < DIV_BITS; s++) begin
        dv[ln][s]       = DV_W'(r[ln]) << (DIV_BITS - 1 - s);
        fits[ln][s]     = DV_W'(rem[ln][s]) >= dv[ln][s];
        rem_next[ln][s] = fits[ln][s] ? (rem[ln][s] - dv[ln][s][REM_W-1:0]) : rem[ln][s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_BITS; s++) side[s] <= '0;
    end else begin
      side[0] <= in_side;
      for (int s = 0; s < DIV_BITS; s++) side[s+1] <= side[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int ln = 0; ln < 3; ln++) begin
      rem[ln][0]   <= {ad[ln], {FRAC_BITS{1'b0}}};
      quo[ln][0]   <= '0;
      clamp[ln][0] <= {6'b0, ad[ln]} >= {r[ln], 8'b0};
      for (int s = 0; s < DIV_BITS; s++) begin
        rem[ln][s+1]   <= rem_next[ln][s];
        quo[ln][s+1]   <= {quo[ln][s][DIV_BITS-2:0], fits[ln][s]};
        clamp[ln][s+1] <= clamp[ln][s];
      end
    end
  end

  always_comb begin
    for (int ln = 0; ln < 3; ln++) begin
      ratio[ln] = clamp[ln][DIV_BITS] ? '1 : quo[ln][DIV_BITS];
    end
  end

  assign out_side = side[DIV_BITS];

endmodule

[hw/rtl/eda_exp.sv]
// Squared ratio sum and the table-driven exponential stages.
module eda_exp import eda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  side_t               in_side,
  input  logic [DIV_BITS-1:0] ratio [3],
  output side_t               out_side,
  output logic [E_W-1:0]      e
);

  side_t            side1, side2, side3, side4;
  logic [31:0]      sq1 [3];
  logic [X_W-1:0]   x2;
  logic [39:0]      yp3;
  logic [E_W-1:0]   e4;

  logic [47:0]      rr [3];
  logic [33:0]      sum;
  logic [35:0]      x3;
  logic [X_W-1:0]   y;
  logic [6:0]       n;
  logic [EXP_IDX_BITS-1:0] idx;
  logic [30:0]      entry;
  logic [7:0]       shift;
  logic [30:0]      shifted;

  always_comb begin
    for (int i = 0; i < 3; i++) rr[i] = 48'(ratio[i]) * 48'(ratio[i]);
    sum     = 34'(sq1[0]) + 34'(sq1[1]) + 34'(sq1[2]);
    x3      = 36'(sum) + (36'(sum) << 1);
    y       = yp3[X_W+FRAC_BITS-1:FRAC_BITS];
    n       = y[X_W-1:FRAC_BITS];
    idx     = y[FRAC_BITS-1:FRAC_BITS-EXP_IDX_BITS];
    entry   = EXP_TABLE[idx];
    shift   = 8'(EXP_SHIFT_BASE) + {1'b0, n};
    shifted = entry >> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side2 <= '0;
      side3 <= '0;
      side4 <= '0;
    end else begin
      side1 <= in_side;
      side2 <= side1;
      side3 <= side2;
      side4 <= side3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq1[i] <= rr[i][47:FRAC_BITS];
    x2  <= (x3 > 36'(X_MAX)) ? X_MAX : x3[X_W-1:0];
    yp3 <= 40'(x2) * 40'(LOG2E_QF);
    e4  <= (shift >= 8'd31) ? '0 : shifted[E_W-1:0];
  end

  assign out_side = side4;
  assign e        = e4;

endmodule

[hw/rtl/eda_prefactor.sv]
// Bit-serial divider that rebuilds the Q28 prefactor after a radius write.
module eda_prefactor import eda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        recalc,
  input  logic [30:0] radius [3],
  output pf_out_t     pf
);

  pf_state_t        state, state_next;
  logic [1:0]       lane;
  logic [6:0]       cnt;
  logic [P_W-1:0]   pcur;
  logic             big;
  logic [DVD_W-1:0] dvd;
  logic [30:0]      prem;
  logic [P_W-1:0]   quo;

  logic [30:0]      r_sel;
  logic             big_hit;
  logic [31:0]      trial;
  logic             fits;
  logic [30:0]      prem_next;
  logic             last;
  logic             do_load, do_check, do_step;

  always_comb begin
    r_sel     = eff_radius(radius[lane]);
    big_hit   = {16'b0, pcur} >= {1'b0, r_sel, 44'b0};
    trial     = {prem, dvd[DVD_W-1]};
    fits      = trial >= {1'b0, r_sel};
    prem_next = fits ? 31'(trial - {1'b0, r_sel}) : trial[30:0];
    last      = (cnt == 7'(DVD_W - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      PF_IDLE:  state_next = PF_IDLE;
      PF_CHECK: state_next = big_hit ? PF_IDLE : PF_STEP;
      PF_STEP: begin
        if (last) state_next = (lane == 2'd2) ? PF_IDLE : PF_CHECK;
      end
      default:  state_next = PF_IDLE;
    endcase
    if (recalc) state_next = PF_CHECK;
  end

  always_comb begin
    do_load  = recalc;
    do_check = !recalc && (state == PF_CHECK);
    do_step  = !recalc && (state == PF_STEP);
    pf.busy  = (state != PF_IDLE);
    pf.big   = big;
    pf.p     = pcur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PF_IDLE;
      lane  <= 2'd0;
      cnt   <= 7'd0;
      pcur  <= P_W'(K_Q28);
      big   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_load) begin
        lane <= 2'd0;
        pcur <= P_W'(K_Q28);
        big  <= 1'b0;
      end else if (do_check) begin
        cnt <= 7'd0;
        if (big_hit) big <= 1'b1;
      end else if (do_step) begin
        cnt <= cnt + 7'd1;
        if (last) begin
          pcur <= {quo[P_W-2:0], fits};
          lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_check) begin
      dvd  <= {pcur, {FRAC_BITS{1'b0}}};
      prem <= '0;
    end else if (do_step) begin
      dvd  <= dvd << 1;
      prem <= prem_next;
      quo  <= {quo[P_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/ellipsoid_deposition_activation_core.sv]
// Top level of the moving ellipsoid deposition source with level-set activation.
//
// Usage: a transaction is taken at a rising edge where start is high and busy is
// low. Each transaction carries one point, its prior activation flag and the
// current track (start position, scan length, elapsed time). The core computes
// the ellipsoid field value at the point and whether the point is active.
// Results come out in order on active, scan_over and field_value, valid for
// exactly one cycle while done is high; the receiver cannot stall them.
// Throughput is one transaction per cycle while busy is low. The path is
// three travel stages, a 25-stage divider pipeline (a load stage, then one
// quotient bit per stage), four exponent stages and two product and output
// stages. Configuration registers are written through cfg_write, cfg_index
// and cfg_data; the user must write them only while no transaction is in
// flight, as the core does not enforce this. A write to any radius register
// restarts the prefactor unit, a shared bit-serial divider that divides the
// constant by each radius in turn; busy stays high until the third division
// ends or the prefactor saturates, and no transaction is taken meanwhile.
// Reset is synchronous: it empties the pipeline, loads the register reset
// values and the matching prefactor, and holds busy high while asserted.
module ellipsoid_deposition_activation_core import eda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [31:0]        elapsed_time,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic [30:0]        track_length,
  input  logic               old_active,
  output logic               done,
  output logic               active,
  output logic               scan_over,
  output logic [31:0]        field_value,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int PIPE_LATENCY = 34;

  // Configuration registers.
  logic [30:0]        radius_x, radius_y, radius_z;
  logic signed [31:0] velocity_x, velocity_y, velocity_z;
  logic [31:0]        activation_threshold;

  logic               recalc;
  pf_out_t            pf;

  side_t              in_side, tr_side, dv_side, ex_side, f1_side;
  logic signed [31:0] point [3];
  logic signed [31:0] start_pos [3];
  logic signed [31:0] vel [3];
  logic [30:0]        radius [3];
  logic [AD_W-1:0]    ad [3];
  logic [DIV_BITS-1:0] ratio [3];
  logic [E_W-1:0]     e;

  // Final product stage.
  logic [48:0]        mul_hi;
  logic [E_W-1:0]     mul_lo;
  logic               e_zero;
  logic               big1;
  logic [44:0]        plo_e;
  logic [49:0]        val_full;
  logic [31:0]        val;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x             <= RADIUS_RESET;
      radius_y             <= RADIUS_RESET;
      radius_z             <= RADIUS_RESET;
      velocity_x           <= '0;
      velocity_y           <= '0;
      velocity_z           <= '0;
      activation_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS_X:   radius_x             <= cfg_data[30:0];
        REG_RADIUS_Y:   radius_y             <= cfg_data[30:0];
        REG_RADIUS_Z:   radius_z             <= cfg_data[30:0];
        REG_VELOCITY_X: velocity_x           <= cfg_data;
        REG_VELOCITY_Y: velocity_y           <= cfg_data;
        REG_VELOCITY_Z: velocity_z           <= cfg_data;
        REG_THRESHOLD:  activation_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a radius change moves the prefactor.
  assign recalc = cfg_write &&
                  (reg_idx_t'(cfg_index) inside {REG_RADIUS_X, REG_RADIUS_Y, REG_RADIUS_Z});

  assign radius[0] = radius_x;
  assign radius[1] = radius_y;
  assign radius[2] = radius_z;

  eda_prefactor u_prefactor (
    .clk    (clk),
    .rst    (rst),
    .recalc (recalc),
    .radius (radius),
    .pf     (pf)
  );

  assign busy = rst | pf.busy;

  assign in_side.valid = start && !busy;
  assign in_side.over  = 1'b0;
  assign in_side.old   = old_active;

  assign point[0]     = point_x;
  assign point[1]     = point_y;
  assign point[2]     = point_z;
  assign start_pos[0] = start_x;
  assign start_pos[1] = start_y;
  assign start_pos[2] = start_z;
  assign vel[0]       = velocity_x;
  assign vel[1]       = velocity_y;
  assign vel[2]       = velocity_z;

  eda_travel u_travel (
    .clk       (clk),
    .rst       (rst),
    .in_side   (in_side),
    .point     (point),
    .start_pos (start_pos),
    .elapsed   (elapsed_time),
    .len       (track_length),
    .vel       (vel),
    .out_side  (tr_side),
    .ad        (ad)
  );

  eda_ratio_div u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .in_side  (tr_side),
    .ad       (ad),
    .radius   (radius),
    .out_side (dv_side),
    .ratio    (ratio)
  );

  eda_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_side  (dv_side),
    .ratio    (ratio),
    .out_side (ex_side),
    .e        (e)
  );

  // The Q28 prefactor is split in two parts so each multiply stays narrow;
  // the sum below is exactly floor(P * E / 2^28).
  assign plo_e = 45'(pf.p[27:0]) * 45'(e);

  always_comb begin
    val_full = 50'(mul_hi) + 50'(mul_lo);
    if (e_zero || f1_side.over) begin
      val = '0;
    end else if (big1 || (val_full > 50'h0_FFFF_FFFF)) begin
      val = '1;
    end else begin
      val = val_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_side <= '0;
      done    <= 1'b0;
    end else begin
      f1_side <= ex_side;
      done    <= f1_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    mul_hi      <= 49'(pf.p[P_W-1:28]) * 49'(e);
    mul_lo      <= plo_e[44:28];
    e_zero      <= (e == '0);
    big1        <= pf.big;
    active      <= f1_side.old | (val > activation_threshold);
    scan_over   <= f1_side.over;
    field_value <= val;
  end

  // Every taken transaction produces its result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("result strobe missing after a taken transaction");

  // No result appears without a transaction taken at the matching edge.
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching transaction");

  // A finished scan always reports a zero field.
  a_scan_zero: assert property (@(posedge clk) disable iff (rst)
    (done && scan_over) |-> (field_value == 32'd0))
    else $error("nonzero field value with scan over");

  // The prefactor unit only starts on a radius write.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    (!busy && !recalc) |=> !busy)
    else $error("busy raised without a radius write");

endmodule
